/* sv/dcm_pkg.sv */
package dcm_pkg;

    localparam int ADDR_BITS     = 10;
    localparam int WORDS         = 1 << ADDR_BITS;
    localparam int WORD_BITS     = 32;
    localparam int REG_BITS      = 16;
    localparam int EPOCH_BITS    = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int S_TDATA_BITS  = ((ADDR_BITS + WORD_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS  = 4;
    localparam int M_TDATA_BITS  = WORD_BITS;

    localparam logic [REG_BITS-1:0] RST_REFRESH_INTERVAL = 16'd1024;
    localparam logic [REG_BITS-1:0] RST_REFRESH_DELAY    = 16'd8;
    localparam logic [REG_BITS-1:0] RST_ACTIVATE_DELAY   = 16'd3;
    localparam logic [REG_BITS-1:0] RST_CAS_LATENCY      = 16'd3;
    localparam logic [REG_BITS-1:0] RST_PRECHARGE_DELAY  = 16'd3;

    localparam logic [WORD_BITS-1:0] CORRUPT_WORD = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_REFRESH_INTERVAL = 3'd0,
        REG_REFRESH_DELAY    = 3'd1,
        REG_ACTIVATE_DELAY   = 3'd2,
        REG_CAS_LATENCY      = 3'd3,
        REG_PRECHARGE_DELAY  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [REG_BITS-1:0] refresh_interval;
        logic [REG_BITS-1:0] refresh_delay;
        logic [REG_BITS-1:0] activate_delay;
        logic [REG_BITS-1:0] cas_latency;
        logic [REG_BITS-1:0] precharge_delay;
    } cfg_t;

    typedef struct packed {
        logic                  chip_select;
        logic                  row_strobe;
        logic                  column_strobe;
        logic                  write_enable;
        logic [ADDR_BITS-1:0]  word_address;
        logic [WORD_BITS-1:0]  write_word;
    } item_t;

    // One word of storage: written flag, refresh epoch at the last write, data.
    typedef struct packed {
        logic                   written;
        logic [EPOCH_BITS-1:0]  epoch;
        logic [WORD_BITS-1:0]   data;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic                  en;
        logic [ADDR_BITS-1:0]  addr;
        entry_t                entry;
    } mem_wr_t;

endpackage

/* sv/dram_command_timing_model.sv */
// An accepted item is registered into the execute stage, and its result then into the
// output register that drives m_tvalid. Throughput: one item per cycle while m_ is not stalled.
// The word store is read in the accept cycle and updated when a write access completes.
// Reset (aresetn low, synchronous) restores the default registers and state, then a
// clearing sweep over all 1024 words resets the written flags with s_tready held low;
// configuration writes are taken during the sweep.
module dram_command_timing_model (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [dcm_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
    input  logic [dcm_pkg::REG_BITS-1:0]         cfg_wdata,
    // Command bus, one transfer per tick
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata: word_address[9:0], write_word[41:10], zero padding above
    input  logic [dcm_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // s_tuser: chip_select[0], row_strobe[1], column_strobe[2], write_enable[3]
    input  logic [dcm_pkg::S_TUSER_BITS-1:0]     s_tuser,
    // Results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata: read_word[31:0]
    output logic [dcm_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // m_tuser: complete[0]
    output logic                                 m_tuser
);

    localparam int AB = dcm_pkg::ADDR_BITS;
    localparam int WB = dcm_pkg::WORD_BITS;

    dcm_pkg::cfg_t      cfg;
    dcm_pkg::item_t     in_item;
    dcm_pkg::item_t     item_reg;
    dcm_pkg::entry_t    ram_rdata;
    dcm_pkg::entry_t    rd_entry;
    dcm_pkg::entry_t    byp_entry_reg;
    dcm_pkg::mem_wr_t   exec_wr;
    dcm_pkg::mem_wr_t   ram_wr;

    logic [AB:0]        clr_cnt_reg;
    logic               clr_done;
    logic               s2_valid_reg;
    logic               s2_fire;
    logic               accept;
    logic               byp_hit_reg;
    logic               exec_complete;
    logic [WB-1:0]      exec_word;
    logic               m_tvalid_reg;
    logic               m_complete_reg;
    logic [WB-1:0]      m_word_reg;

    // Unpack the incoming transfer.
    assign in_item.chip_select   = s_tuser[0];
    assign in_item.row_strobe    = s_tuser[1];
    assign in_item.column_strobe = s_tuser[2];
    assign in_item.write_enable  = s_tuser[3];
    assign in_item.word_address  = s_tdata[AB-1:0];
    assign in_item.write_word    = s_tdata[AB+WB-1:AB];

    // Sweep the store once after reset so every word starts unwritten.
    assign clr_done = clr_cnt_reg[AB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (!clr_done) begin
            clr_cnt_reg <= clr_cnt_reg + {{AB{1'b0}}, 1'b1};
        end
    end

    // The execute stage advances when the output register is free or draining.
    assign s2_fire  = s2_valid_reg & (~m_tvalid_reg | m_tready);
    assign s_tready = clr_done & (~s2_valid_reg | s2_fire);
    assign accept   = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (accept) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_fire) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
    end

    // The write of the completing item lands at the same edge that launches the next
    // read; hold a copy so a read of that same word sees the new contents.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else if (accept) begin
            byp_hit_reg <= exec_wr.en & (exec_wr.addr == in_item.word_address);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byp_entry_reg <= exec_wr.entry;
        end
    end

    assign rd_entry = byp_hit_reg ? byp_entry_reg : ram_rdata;

    // Store write port: clearing sweep first, then item writes.
    always_comb begin
        if (!clr_done) begin
            ram_wr.en    = 1'b1;
            ram_wr.addr  = clr_cnt_reg[AB-1:0];
            ram_wr.entry = '0;
        end else begin
            ram_wr = exec_wr;
        end
    end

    dcm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dcm_ram #(
        .WIDTH (dcm_pkg::ENTRY_BITS),
        .DEPTH (dcm_pkg::WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.entry),
        .rd_en   (accept),
        .rd_addr (in_item.word_address),
        .rd_data (ram_rdata)
    );

    dcm_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s2_fire),
        .item      (item_reg),
        .rd_entry  (rd_entry),
        .cfg       (cfg),
        .complete  (exec_complete),
        .read_word (exec_word),
        .mem_wr    (exec_wr)
    );

    // Output register: hold the result until the downstream transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s2_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_fire) begin
            m_complete_reg <= exec_complete;
            m_word_reg     <= exec_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_word_reg;
    assign m_tuser  = m_complete_reg;

endmodule

/* sv/dcm_ram.sv */
module dcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/dcm_cfg.sv */
module dcm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dcm_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [dcm_pkg::REG_BITS-1:0]      cfg_wdata,
    output dcm_pkg::cfg_t                     cfg
);

    dcm_pkg::cfg_t cfg_reg;
    dcm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (dcm_pkg::cfg_idx_t'(cfg_addr))
                dcm_pkg::REG_REFRESH_INTERVAL: cfg_next.refresh_interval = cfg_wdata;
                dcm_pkg::REG_REFRESH_DELAY:    cfg_next.refresh_delay    = cfg_wdata;
                dcm_pkg::REG_ACTIVATE_DELAY:   cfg_next.activate_delay   = cfg_wdata;
                dcm_pkg::REG_CAS_LATENCY:      cfg_next.cas_latency      = cfg_wdata;
                dcm_pkg::REG_PRECHARGE_DELAY:  cfg_next.precharge_delay  = cfg_wdata;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.refresh_interval <= dcm_pkg::RST_REFRESH_INTERVAL;
            cfg_reg.refresh_delay    <= dcm_pkg::RST_REFRESH_DELAY;
            cfg_reg.activate_delay   <= dcm_pkg::RST_ACTIVATE_DELAY;
            cfg_reg.cas_latency      <= dcm_pkg::RST_CAS_LATENCY;
            cfg_reg.precharge_delay  <= dcm_pkg::RST_PRECHARGE_DELAY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/dcm_exec.sv */
module dcm_exec (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  dcm_pkg::item_t                  item,
    input  dcm_pkg::entry_t                 rd_entry,
    input  dcm_pkg::cfg_t                   cfg,
    output logic                            complete,
    output logic [dcm_pkg::WORD_BITS-1:0]   read_word,
    output dcm_pkg::mem_wr_t                mem_wr
);

    typedef enum logic [5:0] {
        CMD_NONE      = 6'b000001,
        CMD_LAUNCH    = 6'b000010,
        CMD_REFRESH   = 6'b000100,
        CMD_ACTIVATE  = 6'b001000,
        CMD_ACCESS    = 6'b010000,
        CMD_PRECHARGE = 6'b100000
    } cmd_t;

    logic [dcm_pkg::REG_BITS-1:0]   timer_reg, timer_next, timer_inc, timer_mid;
    logic [dcm_pkg::EPOCH_BITS-1:0] epoch_reg, epoch_next, epoch_mid;
    logic                           active_reg, active_next, active_mid;
    logic                           idle_reg, idle_next;
    logic [dcm_pkg::REG_BITS-1:0]   cnt_reg, cnt_next;
    logic                           expire;
    cmd_t                           cmd;
    logic [dcm_pkg::REG_BITS-1:0]   delay;
    logic [dcm_pkg::REG_BITS-1:0]   load;
    logic                           done;
    logic [dcm_pkg::WORD_BITS-1:0]  stored_word;

    // Refresh timer runs first: expiry deactivates and starts a new epoch.
    assign timer_inc  = timer_reg + 16'd1;
    assign expire     = (timer_inc == cfg.refresh_interval);
    assign timer_mid  = expire ? '0 : timer_inc;
    assign epoch_mid  = epoch_reg + {{(dcm_pkg::EPOCH_BITS-1){1'b0}}, expire};
    assign active_mid = active_reg & ~expire;

    always_comb begin
        if (item.chip_select && !item.row_strobe && !item.column_strobe) begin
            cmd = CMD_LAUNCH;
        end else if (item.chip_select) begin
            cmd = CMD_NONE;
        end else if (!item.row_strobe && !item.column_strobe && item.write_enable) begin
            cmd = CMD_REFRESH;
        end else if (!item.row_strobe && item.column_strobe && item.write_enable) begin
            cmd = CMD_ACTIVATE;
        end else if (item.row_strobe && !item.column_strobe && active_mid) begin
            cmd = CMD_ACCESS;
        end else if (!item.row_strobe && item.column_strobe && !item.write_enable) begin
            cmd = CMD_PRECHARGE;
        end else begin
            cmd = CMD_NONE;
        end
    end

    always_comb begin
        case (cmd)
            CMD_REFRESH:   delay = cfg.refresh_delay;
            CMD_ACTIVATE:  delay = cfg.activate_delay;
            CMD_ACCESS:    delay = cfg.cas_latency;
            CMD_PRECHARGE: delay = cfg.precharge_delay;
            default:       delay = '0;
        endcase
    end

    // An idle countdown picks up this command's delay; otherwise continue.
    assign load = idle_reg ? delay : cnt_reg;

    // Corrupted words read all ones; never-written words read zero.
    always_comb begin
        if (!rd_entry.written) begin
            stored_word = '0;
        end else if (rd_entry.epoch != epoch_mid) begin
            stored_word = dcm_pkg::CORRUPT_WORD;
        end else begin
            stored_word = rd_entry.data;
        end
    end

    always_comb begin
        timer_next  = timer_mid;
        epoch_next  = epoch_mid;
        active_next = active_mid;
        idle_next   = idle_reg;
        cnt_next    = cnt_reg;
        done        = 1'b0;
        read_word   = '0;
        case (cmd)
            CMD_LAUNCH: begin
                idle_next = 1'b1;
            end
            CMD_REFRESH, CMD_ACTIVATE, CMD_ACCESS, CMD_PRECHARGE: begin
                if (load != '0) begin
                    cnt_next  = load - 16'd1;
                    idle_next = 1'b0;
                end else begin
                    idle_next = 1'b1;
                    done      = 1'b1;
                end
            end
            default: begin
                idle_next = idle_reg;
            end
        endcase
        if (done) begin
            case (cmd)
                CMD_REFRESH: begin
                    timer_next  = '0;
                    active_next = 1'b0;
                end
                CMD_ACTIVATE: begin
                    active_next = 1'b1;
                end
                CMD_ACCESS: begin
                    read_word = item.write_enable ? stored_word : item.write_word;
                end
                CMD_PRECHARGE: begin
                    active_next = 1'b0;
                end
                default: begin
                    active_next = active_mid;
                end
            endcase
        end
    end

    assign complete            = done;
    assign mem_wr.en           = fire & done & (cmd == CMD_ACCESS) & ~item.write_enable;
    assign mem_wr.addr         = item.word_address;
    assign mem_wr.entry.written = 1'b1;
    assign mem_wr.entry.epoch  = epoch_mid;
    assign mem_wr.entry.data   = item.write_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg  <= '0;
            epoch_reg  <= '0;
            active_reg <= 1'b0;
            idle_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else if (fire) begin
            timer_reg  <= timer_next;
            epoch_reg  <= epoch_next;
            active_reg <= active_next;
            idle_reg   <= idle_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* test/tb_dram_command_timing_model.sv */
module tb_dram_command_timing_model;
    import dcm_pkg::*;

    // Command pins as they sit on s_tuser: {write_enable, column_strobe, row_strobe, chip_select}
    localparam logic [S_TUSER_BITS-1:0] PINS_LAUNCH        = 4'b0001;
    localparam logic [S_TUSER_BITS-1:0] PINS_LAUNCH_WE     = 4'b1001;
    localparam logic [S_TUSER_BITS-1:0] PINS_REFRESH       = 4'b1000;
    localparam logic [S_TUSER_BITS-1:0] PINS_ACTIVATE      = 4'b1100;
    localparam logic [S_TUSER_BITS-1:0] PINS_READ          = 4'b1010;
    localparam logic [S_TUSER_BITS-1:0] PINS_WRITE         = 4'b0010;
    localparam logic [S_TUSER_BITS-1:0] PINS_PRECHARGE     = 4'b0100;
    // Patterns that decode to no command
    localparam logic [S_TUSER_BITS-1:0] PINS_NOP_ALL_LOW   = 4'b0000;
    localparam logic [S_TUSER_BITS-1:0] PINS_NOP_ALL_HIGH  = 4'b1111;
    localparam logic [S_TUSER_BITS-1:0] PINS_NOP_RAS_CAS   = 4'b0110;

    // Register indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [16:0] CD_IDLE = -17'sd1;

    localparam int MAX_IDLE       = 11;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 7;
    localparam int PHASE_TICKS    = 240;
    localparam int WRAP_FILL      = 40;
    localparam int SHOWN_ERRORS   = 10;

    typedef enum {
        CMD_LAUNCH,
        CMD_REFRESH,
        CMD_ACTIVATE,
        CMD_READ,
        CMD_WRITE,
        CMD_PRECHARGE
    } cmd_t;

    typedef struct packed {
        logic                  complete;
        logic [WORD_BITS-1:0]  word;
    } tick_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_addr;
    logic [REG_BITS-1:0]      cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;
    logic [S_TUSER_BITS-1:0]  s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     m_tuser;

    dram_command_timing_model uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow copy of the timing registers
    logic [REG_BITS-1:0] reg_interval      = RST_REFRESH_INTERVAL;
    logic [REG_BITS-1:0] reg_refresh_delay = RST_REFRESH_DELAY;
    logic [REG_BITS-1:0] reg_activate      = RST_ACTIVATE_DELAY;
    logic [REG_BITS-1:0] reg_cas           = RST_CAS_LATENCY;
    logic [REG_BITS-1:0] reg_precharge     = RST_PRECHARGE_DELAY;

    // Shadow copy of the device state; the countdown comes out of reset at zero, not idle
    logic signed [16:0]   cd_left    = '0;
    logic [REG_BITS-1:0]  tick_timer = '0;
    bit                   bank_open  = 1'b0;
    logic [WORD_BITS-1:0] mem_word    [WORDS];
    bit                   mem_written [WORDS];
    bit                   mem_corrupt [WORDS];
    int                   filled_addrs[$];

    tick_result_t tick_outcomes[$];
    int           bad_ticks  = 0;
    int           ticks_sent = 0;
    bit           tx_idle    = 1'b1;
    bit           rx_idle    = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------------------
    // Device prediction
    // ---------------------------------------------------------------------------------

    // Shared countdown: load only when idle, count down, finish on the tick it sits at zero.
    function automatic bit step_countdown(input logic [REG_BITS-1:0] delay);
        if (cd_left == CD_IDLE)
            cd_left = $signed({1'b0, delay});
        if (cd_left > 0) begin
            cd_left = cd_left - 17'sd1;
            return 1'b0;
        end
        cd_left = CD_IDLE;
        return 1'b1;
    endfunction

    function automatic tick_result_t dram_tick(input logic [S_TUSER_BITS-1:0] pins,
                                               input logic [ADDR_BITS-1:0]    addr,
                                               input logic [WORD_BITS-1:0]    data);
        tick_result_t r;
        logic         cs, ras, cas, we;
        int           k;
        {we, cas, ras, cs} = pins;
        r = '0;

        // Timer expiry comes first: corrupt every stored word and close the bank.
        tick_timer = tick_timer + 16'd1;
        if (tick_timer == reg_interval) begin
            tick_timer = '0;
            for (k = 0; k < filled_addrs.size(); k++)
                mem_corrupt[filled_addrs[k]] = 1'b1;
            bank_open = 1'b0;
        end

        if (cs && !ras && !cas) begin
            cd_left = CD_IDLE;
        end else if (!cs && !ras && !cas && we) begin
            if (step_countdown(reg_refresh_delay)) begin
                tick_timer = '0;
                bank_open  = 1'b0;
                r.complete = 1'b1;
            end
        end else if (!cs && !ras && cas && we) begin
            if (step_countdown(reg_activate)) begin
                bank_open  = 1'b1;
                r.complete = 1'b1;
            end
        end else if (!cs && ras && !cas && bank_open) begin
            if (step_countdown(reg_cas)) begin
                if (we) begin
                    if (!mem_written[addr])
                        r.word = '0;
                    else if (mem_corrupt[addr])
                        r.word = CORRUPT_WORD;
                    else
                        r.word = mem_word[addr];
                end else begin
                    if (!mem_written[addr])
                        filled_addrs.push_back(int'(addr));
                    mem_word[addr]    = data;
                    mem_written[addr] = 1'b1;
                    mem_corrupt[addr] = 1'b0;
                    r.word            = data;
                end
                r.complete = 1'b1;
            end
        end else if (!cs && !ras && cas && !we) begin
            if (step_countdown(reg_precharge)) begin
                bank_open  = 1'b0;
                r.complete = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [S_TUSER_BITS-1:0] pins_of(input cmd_t c);
        case (c)
            CMD_LAUNCH:    return $urandom_range(0, 1) ? PINS_LAUNCH_WE : PINS_LAUNCH;
            CMD_REFRESH:   return PINS_REFRESH;
            CMD_ACTIVATE:  return PINS_ACTIVATE;
            CMD_READ:      return PINS_READ;
            CMD_WRITE:     return PINS_WRITE;
            default:       return PINS_PRECHARGE;
        endcase
    endfunction

    // ---------------------------------------------------------------------------------
    // Bus drivers
    // ---------------------------------------------------------------------------------

    // Write one timing register; only called while no transfer is in flight.
    task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_REFRESH_INTERVAL: reg_interval      = val;
            REG_REFRESH_DELAY:    reg_refresh_delay = val;
            REG_ACTIVATE_DELAY:   reg_activate      = val;
            REG_CAS_LATENCY:      reg_cas           = val;
            REG_PRECHARGE_DELAY:  reg_precharge     = val;
            default: ;
        endcase
    endtask

    // Send one command tick and record its predicted outcome once the transfer lands.
    task automatic issue_tick(input logic [S_TUSER_BITS-1:0] pins,
                              input logic [ADDR_BITS-1:0]    addr,
                              input logic [WORD_BITS-1:0]    data,
                              output bit                     done);
        int           gap;
        tick_result_t r;
        // Read only words that were written at least once; before any write, turn it
        // into a write instead.
        if (pins == PINS_READ && !mem_written[addr]) begin
            if (filled_addrs.size() > 0)
                addr = ADDR_BITS'(filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]);
            else
                pins = PINS_WRITE;
        end
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= pins;
        s_tdata  <= {{(S_TDATA_BITS - ADDR_BITS - WORD_BITS){1'b0}}, data, addr};
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = dram_tick(pins, addr, data);
        tick_outcomes.push_back(r);
        ticks_sent++;
        done = r.complete;
    endtask

    // Drop valid and wait for every outstanding result, plus the pipeline depth.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tick_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------------------
    // Result checker: random back-pressure, compare each transfer with the oldest outcome
    // ---------------------------------------------------------------------------------
    initial begin : result_check
        tick_result_t want;
        tick_result_t got;
        int           stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got.complete = m_tuser;
            got.word     = m_tdata;
            if (tick_outcomes.size() == 0) begin
                if (bad_ticks < SHOWN_ERRORS)
                    $display("unexpected result transfer: complete %0b read_word %h",
                             got.complete, got.word);
                bad_ticks++;
            end else begin
                want = tick_outcomes.pop_front();
                if (got.complete !== want.complete || got.word !== want.word) begin
                    if (bad_ticks < SHOWN_ERRORS)
                        $display("result %0d: complete exp %0b got %0b, read_word exp %h got %h",
                                 ticks_sent - tick_outcomes.size() - 1, want.complete,
                                 got.complete, want.word, got.word);
                    bad_ticks++;
                end
            end
        end
    end

    // Stop the run if neither channel moves a transfer for too long. The limit covers
    // the clearing sweep after reset as well as the longest stall on either side.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("dram_command_timing_model: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // The countdown leaves reset at zero, so the first command finishes on its own tick.
    task automatic test_first_command();
        bit done;
        issue_tick(PINS_ACTIVATE, '0, '0, done);
        settle();
    endtask

    // Writes to indexes past the last register must leave every delay untouched.
    task automatic test_spare_registers();
        set_reg(REG_SPARE_LO, 16'hFFFF);
        set_reg(REG_SPARE_HI, 16'h0000);
    endtask

    // Walk every command with short delays, field extremes and the shared countdown.
    task automatic test_command_set();
        bit done;
        set_reg(REG_REFRESH_INTERVAL, 16'd300);
        set_reg(REG_REFRESH_DELAY, 16'd2);
        set_reg(REG_ACTIVATE_DELAY, 16'd1);
        set_reg(REG_CAS_LATENCY, 16'd0);
        set_reg(REG_PRECHARGE_DELAY, 16'd0);

        issue_tick(PINS_LAUNCH_WE, '0, '0, done);
        issue_tick(PINS_PRECHARGE, '0, '0, done);
        // bank closed: the write must be dropped
        issue_tick(PINS_WRITE, '1, '1, done);
        repeat (2) issue_tick(PINS_ACTIVATE, '0, '0, done);
        issue_tick(PINS_WRITE, '1, '1, done);
        issue_tick(PINS_WRITE, '0, '0, done);
        issue_tick(PINS_READ, '1, '0, done);
        issue_tick(PINS_READ, '0, '1, done);
        issue_tick(PINS_NOP_ALL_LOW, '1, '1, done);
        issue_tick(PINS_NOP_ALL_HIGH, '0, '0, done);
        // activate leaves the countdown at zero; the write picks it up and finishes at once
        issue_tick(PINS_ACTIVATE, '0, '0, done);
        issue_tick(PINS_WRITE, 10'h155, 32'hAAAA_5555, done);
        repeat (3) issue_tick(PINS_REFRESH, '0, '0, done);
        issue_tick(PINS_LAUNCH, '0, '0, done);
        settle();
    endtask

    // Let the refresh timer expire with data stored, then rewrite a corrupted word.
    task automatic test_refresh_expiry();
        bit done;
        set_reg(REG_REFRESH_INTERVAL, 16'd5);
        set_reg(REG_ACTIVATE_DELAY, 16'd0);
        issue_tick(PINS_ACTIVATE, '0, '0, done);
        issue_tick(PINS_WRITE, 10'h02A, $urandom, done);
        repeat (2) issue_tick(PINS_NOP_RAS_CAS, '1, '1, done);
        issue_tick(PINS_ACTIVATE, '0, '0, done);
        issue_tick(PINS_READ, 10'h02A, '0, done);
        issue_tick(PINS_WRITE, 10'h02A, $urandom, done);
        issue_tick(PINS_READ, 10'h02A, '0, done);
        settle();
    endtask

    // Interval zero: the timer never matches before it wraps, so stored data survives.
    task automatic test_timer_wrap();
        bit done;
        int n;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_reg(REG_REFRESH_INTERVAL, 16'd0);
        set_reg(REG_REFRESH_DELAY, 16'd0);
        set_reg(REG_CAS_LATENCY, 16'd0);
        issue_tick(PINS_LAUNCH, '0, '0, done);
        issue_tick(PINS_REFRESH, '0, '0, done);
        issue_tick(PINS_ACTIVATE, '0, '0, done);
        issue_tick(PINS_WRITE, 10'h007, $urandom, done);
        for (n = 0; n < WRAP_FILL; n++)
            issue_tick(n[0] ? PINS_NOP_ALL_HIGH : PINS_NOP_RAS_CAS, ADDR_BITS'($urandom),
                       $urandom, done);
        issue_tick(PINS_ACTIVATE, '0, '0, done);
        issue_tick(PINS_READ, 10'h007, '0, done);
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Mostly command bursts held until they finish or hit a repeat limit, with random pin noise
    // in between. Each phase reprograms every register; one phase runs with no idling at all.
    task automatic test_random_traffic();
        bit                   done;
        bit                   pinned;
        int                   ph, pick, reps, dmax, start;
        cmd_t                 c;
        logic [REG_BITS-1:0]  iv;
        logic [ADDR_BITS-1:0] addr;
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            pinned = 1'b0;
            case (ph)
                0: begin
                    iv   = REG_BITS'($urandom_range(50, 400));
                    dmax = 3;
                end
                1: begin
                    iv   = 16'd1;
                    dmax = 2;
                end
                2: begin
                    iv   = 16'hFFFF;
                    dmax = 5;
                end
                3: begin
                    iv     = 16'hFFFF;
                    dmax   = 0;
                    pinned = 1'b1;
                end
                4: begin
                    iv   = REG_BITS'($urandom_range(2, 20));
                    dmax = 0;
                end
                default: begin
                    iv   = REG_BITS'($urandom_range(8, 2000));
                    dmax = 6;
                end
            endcase
            set_reg(REG_REFRESH_INTERVAL, iv);
            set_reg(REG_REFRESH_DELAY, pinned ? 16'hFFFF : REG_BITS'($urandom_range(0, dmax)));
            set_reg(REG_ACTIVATE_DELAY, pinned ? 16'hFFFF : REG_BITS'($urandom_range(0, dmax)));
            set_reg(REG_CAS_LATENCY, pinned ? 16'hFFFF : REG_BITS'($urandom_range(0, dmax)));
            set_reg(REG_PRECHARGE_DELAY, pinned ? 16'hFFFF : REG_BITS'($urandom_range(0, dmax)));
            tx_idle = (ph % 3) != 1;
            rx_idle = (ph % 2) == 0;

            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                if ($urandom_range(0, 99) < 75) begin
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0, 1:    c = CMD_ACTIVATE;
                        2, 3, 4: c = CMD_WRITE;
                        5, 6, 7: c = CMD_READ;
                        8:       c = CMD_PRECHARGE;
                        default: c = $urandom_range(0, 1) ? CMD_REFRESH : CMD_LAUNCH;
                    endcase
                    // a small pool of addresses keeps reads landing on stored words
                    addr = ($urandom_range(0, 3) == 0) ? ADDR_BITS'($urandom_range(0, WORDS - 1))
                                                       : ADDR_BITS'($urandom_range(0, 15));
                    reps = 0;
                    do begin
                        issue_tick(pins_of(c), addr, $urandom, done);
                        reps++;
                    end while (!done && reps < 12 && c != CMD_LAUNCH);
                end else begin
                    repeat ($urandom_range(1, 4))
                        issue_tick(S_TUSER_BITS'($urandom_range(0, 15)),
                                   ADDR_BITS'($urandom_range(0, WORDS - 1)),
                                   $urandom, done);
                end
            end
        end
        settle();
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_REFRESH_INTERVAL;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_first_command();
        test_spare_registers();
        test_command_set();
        test_refresh_expiry();
        test_timer_wrap();
        test_random_traffic();

        if (bad_ticks == 0)
            $display("dram_command_timing_model: match");
        else
            $display("dram_command_timing_model: mismatch");
        $finish;
    end

endmodule
